// File: rtl/swm_pkg.sv
package swm_pkg;

    // Parameter defaults
    localparam int WINDOW_MAX_DEF  = 64;
    localparam int SAMPLE_BITS_DEF = 32;

    // Configuration port
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = APB_ADDR_W - 2;
    localparam int WSIZE_W    = 7;

    localparam logic [REG_IDX_W-1:0] REG_WINDOW_SIZE = REG_IDX_W'(0);
    localparam logic [WSIZE_W-1:0]   WSIZE_RESET     = WSIZE_W'(3);

    // Per-entry flags handed between neighboring cells
    typedef struct packed {
        logic vld;  // entry holds a window sample
        logic le;   // entry value <= incoming sample
    } t_flags;

    // Cell status seen by the top level
    typedef struct packed {
        logic vld;  // cell is occupied
        logic rm;   // cell holds the oldest sample and leaves this word
    } t_stat;

endpackage

// File: rtl/swm_stream_if.sv
interface swm_sample_if #(
    parameter int SAMPLE_BITS = swm_pkg::SAMPLE_BITS_DEF
) ();
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface swm_median_if #(
    parameter int SAMPLE_BITS = swm_pkg::SAMPLE_BITS_DEF
) ();
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] median;

    modport source (output valid, output median, input ready);
    modport sink   (input valid, input median, output ready);
endinterface

// File: rtl/swm_cell.sv
// One slot of the sorted window: value, age and occupancy.
module swm_cell #(
    parameter int SAMPLE_BITS = swm_pkg::SAMPLE_BITS_DEF,
    parameter int AGE_W       = 6
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_clr,
    input  logic                          i_shift,
    input  logic                          i_full,
    input  logic signed [SAMPLE_BITS-1:0] i_x,
    input  logic [AGE_W-1:0]              i_age_last,
    // compacted entry of the left neighbor
    input  logic signed [SAMPLE_BITS-1:0] i_left_val,
    input  logic [AGE_W-1:0]              i_left_age,
    input  swm_pkg::t_flags               i_left_flags,
    // raw entry of the right neighbor
    input  logic signed [SAMPLE_BITS-1:0] i_right_val,
    input  logic [AGE_W-1:0]              i_right_age,
    input  swm_pkg::t_flags               i_right_flags,
    // removal seen at or left of the previous cell
    input  logic                          i_rm_left,
    output logic                          o_rm_here,
    output logic signed [SAMPLE_BITS-1:0] o_raw_val,
    output logic [AGE_W-1:0]              o_raw_age,
    output swm_pkg::t_flags               o_raw_flags,
    output logic signed [SAMPLE_BITS-1:0] o_cmp_val,
    output logic [AGE_W-1:0]              o_cmp_age,
    output swm_pkg::t_flags               o_cmp_flags,
    output swm_pkg::t_stat                o_stat
);

    logic signed [SAMPLE_BITS-1:0] r_val, n_val;
    logic [AGE_W-1:0]              r_age, n_age;
    logic                          r_vld, n_vld;
    logic                          w_rm;
    logic                          w_shifted;

    assign w_rm      = i_full & r_vld & (r_age == i_age_last);
    assign w_shifted = i_rm_left | w_rm;

    assign o_rm_here       = w_shifted;
    assign o_raw_val       = r_val;
    assign o_raw_age       = r_age;
    assign o_raw_flags.vld = r_vld;
    assign o_raw_flags.le  = r_vld & (r_val <= i_x);
    assign o_stat.vld      = r_vld;
    assign o_stat.rm       = w_rm;

    // Close the gap left by the removed entry
    assign o_cmp_val   = w_shifted ? i_right_val   : r_val;
    assign o_cmp_age   = w_shifted ? i_right_age   : r_age;
    assign o_cmp_flags = w_shifted ? i_right_flags : o_raw_flags;

    // Open a gap for the new sample
    always_comb begin
        if (o_cmp_flags.le) begin
            n_val = o_cmp_val;
            n_age = o_cmp_age + AGE_W'(1);
            n_vld = o_cmp_flags.vld;
        end else if (i_left_flags.le) begin
            n_val = i_x;
            n_age = '0;
            n_vld = 1'b1;
        end else begin
            n_val = i_left_val;
            n_age = i_left_age + AGE_W'(1);
            n_vld = i_left_flags.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clr) begin
            r_vld <= 1'b0;
        end else if (i_shift) begin
            r_vld <= n_vld;
        end
        if (i_shift) begin
            r_val <= n_val;
            r_age <= n_age;
        end
    end

endmodule

// File: rtl/sliding_window_median.sv
// Running lower median over the last K samples.
//
// Input channel i_smp carries one sample word per handshake (valid & ready).
// Output channel o_med carries one median word, the value of ascending rank
// (K-1)/2 in the window. The first K-1 samples after reset or after a write
// of window_size only fill the window and produce no word; every later
// sample produces exactly one.
// Throughput: one sample per cycle while i_smp.ready is high. Every cell of
// the sorted chain updates at the edge that accepts the sample, and r_emit
// marks the result pending; the rank select then loads the output register
// once that register is free, and the median word becomes valid there.
// window_size (APB offset 0) sets K; 0 acts as 1, values above WINDOW_MAX
// act as WINDOW_MAX. A write empties the window. Write it only when idle.
// Reset empties the window, sets K to 3 and drops any pending word.
// When the receiver stalls, the output register holds its word and one more
// result waits in the cells; i_smp.ready then falls until o_med drains.
module sliding_window_median #(
    parameter int WINDOW_MAX  = swm_pkg::WINDOW_MAX_DEF,
    parameter int SAMPLE_BITS = swm_pkg::SAMPLE_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    swm_sample_if.sink                        i_smp,
    swm_median_if.source                      o_med,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [swm_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [swm_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [swm_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready
);

    // Width of a cell index / age, and of a count 0..WINDOW_MAX
    localparam int AGE_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int CNT_W = $clog2(WINDOW_MAX + 1);
    localparam int CMP_W = (CNT_W > swm_pkg::WSIZE_W) ? CNT_W : swm_pkg::WSIZE_W;

    // ---------------- configuration ----------------
    logic [swm_pkg::WSIZE_W-1:0]   r_wsize;
    logic                          w_cfg_wr;
    logic [swm_pkg::REG_IDX_W-1:0] w_reg_idx;

    assign pready    = 1'b1;
    assign w_reg_idx = paddr[swm_pkg::APB_ADDR_W-1:2];
    assign w_cfg_wr  = psel & penable & pwrite & (w_reg_idx == swm_pkg::REG_WINDOW_SIZE);

    always_comb begin
        prdata = '0;
        if (w_reg_idx == swm_pkg::REG_WINDOW_SIZE) begin
            prdata = swm_pkg::APB_DATA_W'(r_wsize);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wsize <= swm_pkg::WSIZE_RESET;
        end else if (w_cfg_wr) begin
            r_wsize <= pwdata[swm_pkg::WSIZE_W-1:0];
        end
    end

    // Effective K, clamped to 1..WINDOW_MAX
    logic [CNT_W-1:0] w_k;
    logic [AGE_W-1:0] w_age_last;  // K-1: age of the oldest sample
    logic [AGE_W-1:0] w_mid;       // (K-1)/2: rank of the lower median

    always_comb begin
        if (r_wsize == '0) begin
            w_k = CNT_W'(1);
        end else if (CMP_W'(r_wsize) > CMP_W'(WINDOW_MAX)) begin
            w_k = CNT_W'(WINDOW_MAX);
        end else begin
            w_k = CNT_W'(r_wsize);
        end
    end

    assign w_age_last = AGE_W'(w_k - CNT_W'(1));
    assign w_mid      = w_age_last >> 1;

    // ---------------- handshake and fill ----------------
    logic             r_emit;       // cells hold a result not yet registered
    logic             r_ovld;
    logic signed [SAMPLE_BITS-1:0] r_med;
    logic [CNT_W-1:0] r_fill, n_fill;
    logic             w_full;
    logic             w_accept;
    logic             w_out_free;
    logic             w_emit_next;

    assign w_full      = (r_fill >= w_k);
    assign w_out_free  = !r_ovld || o_med.ready;
    assign i_smp.ready = !r_emit || w_out_free;
    assign w_accept    = i_smp.valid && i_smp.ready;
    assign n_fill      = w_full ? r_fill : r_fill + CNT_W'(1);
    assign w_emit_next = (n_fill >= w_k);

    assign o_med.valid  = r_ovld;
    assign o_med.median = r_med;

    // ---------------- sorted cell chain ----------------
    logic signed [SAMPLE_BITS-1:0] w_raw_val [WINDOW_MAX+1];
    logic [AGE_W-1:0]              w_raw_age [WINDOW_MAX+1];
    swm_pkg::t_flags               w_raw_flg [WINDOW_MAX+1];
    logic signed [SAMPLE_BITS-1:0] w_cmp_val [WINDOW_MAX+1];
    logic [AGE_W-1:0]              w_cmp_age [WINDOW_MAX+1];
    swm_pkg::t_flags               w_cmp_flg [WINDOW_MAX+1];
    logic [WINDOW_MAX:0]           w_rm_chain;
    swm_pkg::t_stat                w_stat    [WINDOW_MAX];
    logic [WINDOW_MAX-1:0]         w_vld_vec;
    logic [WINDOW_MAX-1:0]         w_rm_vec;

    // Boundaries: nothing right of the last cell; the new sample may
    // always land left of cell 0.
    assign w_raw_val[WINDOW_MAX] = '0;
    assign w_raw_age[WINDOW_MAX] = '0;
    assign w_raw_flg[WINDOW_MAX] = '{vld: 1'b0, le: 1'b0};
    assign w_cmp_val[0]          = '0;
    assign w_cmp_age[0]          = '0;
    assign w_cmp_flg[0]          = '{vld: 1'b1, le: 1'b1};
    assign w_rm_chain[0]         = 1'b0;

    for (genvar j = 0; j < WINDOW_MAX; j++) begin : g_cell
        swm_cell #(
            .SAMPLE_BITS (SAMPLE_BITS),
            .AGE_W       (AGE_W)
        ) u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_clr         (w_cfg_wr),
            .i_shift       (w_accept),
            .i_full        (w_full),
            .i_x           (i_smp.sample),
            .i_age_last    (w_age_last),
            .i_left_val    (w_cmp_val[j]),
            .i_left_age    (w_cmp_age[j]),
            .i_left_flags  (w_cmp_flg[j]),
            .i_right_val   (w_raw_val[j+1]),
            .i_right_age   (w_raw_age[j+1]),
            .i_right_flags (w_raw_flg[j+1]),
            .i_rm_left     (w_rm_chain[j]),
            .o_rm_here     (w_rm_chain[j+1]),
            .o_raw_val     (w_raw_val[j]),
            .o_raw_age     (w_raw_age[j]),
            .o_raw_flags   (w_raw_flg[j]),
            .o_cmp_val     (w_cmp_val[j+1]),
            .o_cmp_age     (w_cmp_age[j+1]),
            .o_cmp_flags   (w_cmp_flg[j+1]),
            .o_stat        (w_stat[j])
        );
        assign w_vld_vec[j] = w_stat[j].vld;
        assign w_rm_vec[j]  = w_stat[j].rm;
    end

    // ---------------- fill count and output register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || w_cfg_wr) begin
            r_fill <= '0;
        end else if (w_accept) begin
            r_fill <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_emit <= 1'b0;
            r_ovld <= 1'b0;
        end else begin
            if (w_accept) begin
                r_emit <= w_emit_next;
            end else if (w_out_free) begin
                r_emit <= 1'b0;
            end
            if (r_emit && w_out_free) begin
                r_ovld <= 1'b1;
            end else if (o_med.ready) begin
                r_ovld <= 1'b0;
            end
        end
    end

    // Median read from the updated chain into the output register
    always_ff @(posedge i_clk) begin
        if (r_emit && w_out_free) begin
            r_med <= w_raw_val[CNT_W'(w_mid)];
        end
    end

    // ---------------- assertions ----------------
    // Occupied cells always match the fill count.
    a_fill_matches_cells: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(w_vld_vec) == int'(r_fill))
        else $error("occupied cell count differs from fill count");

    // A full window always has exactly one oldest cell to drop.
    a_one_oldest: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_full |-> $onehot(w_rm_vec))
        else $error("full window without a unique oldest cell");

    // The fill count never passes K.
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= w_k)
        else $error("fill count above window size");

    // A sample that completes the window leaves a result pending.
    a_emit_after_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_emit_next) |=> r_emit)
        else $error("result lost after a filling sample");

endmodule
